FILE: hdl/soft_knee_gain_vu_meter_defines.svh
// ----------------------------------------------------------------------------
// Soft knee gain VU meter: assertion macros
// Shared property forms for the checker; clocked on clk, reset by rst.
// ----------------------------------------------------------------------------
`ifndef SOFT_KNEE_GAIN_VU_METER_DEFINES_SVH
`define SOFT_KNEE_GAIN_VU_METER_DEFINES_SVH

// condition must hold at every edge outside reset
`define SKG_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next, reset included
`define SKG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/skg_pkg.sv
// ----------------------------------------------------------------------------
// skg_pkg
// Constants, types and helpers shared by the soft knee gain VU meter.
// ----------------------------------------------------------------------------
`default_nettype none

package skg_pkg;

  localparam logic [14:0] MAG_CLAMP  = 15'h7FFF;
  localparam logic [14:0] KNEE_RESET = 15'd24500;
  localparam int          BAR_MAX    = 12;
  localparam int          BAR_STEP   = 2300;
  localparam int          KNEE_SHIFT = 2;

  // register map: one word per register, index taken from paddr[2]
  localparam int          ADDR_W       = 3;
  localparam logic        REG_KNEE_IDX = 1'b0;

  typedef struct packed {
    logic advance;  // word moves from input stage to result stage
    logic last;     // word closes a buffer
  } meter_ctrl_t;

  typedef struct packed {
    logic [3:0]  bars;
    logic [14:0] peak;
  } meter_stat_t;

  // min(BAR_MAX, peak / BAR_STEP) as a row of independent compares
  function automatic logic [3:0] bar_count(input logic [14:0] peak);
    logic [3:0] n;
    n = '0;
    for (int k = 1; k <= BAR_MAX; k++) begin
      if (peak >= 15'(k * BAR_STEP)) begin
        n = 4'(k);
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/skg_shape.sv
// ----------------------------------------------------------------------------
// skg_shape
// Doubles a sample, compresses the part above the knee four to one, clamps.
// ----------------------------------------------------------------------------
`default_nettype none

module skg_shape (
  input  wire logic signed [15:0] sample,
  input  wire logic        [14:0] knee,
  output logic signed      [15:0] shaped,
  output logic             [14:0] mag
);
  import skg_pkg::*;

  logic        negative;
  logic [15:0] abs_val;
  logic [16:0] dbl;
  logic [16:0] knee_ext;
  logic [16:0] comp;

  always_comb begin
    negative = sample[15];
    // -32768 gives 16'h8000, read as unsigned 32768
    abs_val  = negative ? (16'd0 - 16'(sample)) : 16'(sample);
    dbl      = {abs_val, 1'b0};
    knee_ext = {2'b00, knee};
    if (dbl > knee_ext) begin
      comp = knee_ext + ((dbl - knee_ext) >> KNEE_SHIFT);
    end else begin
      comp = dbl;
    end
    if (comp > {2'b00, MAG_CLAMP}) begin
      mag = MAG_CLAMP;
    end else begin
      mag = comp[14:0];
    end
    shaped = negative ? signed'(16'd0 - {1'b0, mag}) : signed'({1'b0, mag});
  end

endmodule

`default_nettype wire

FILE: hdl/skg_meter.sv
// ----------------------------------------------------------------------------
// skg_meter
// Buffer peak tracker and bar meter with one-bar-per-buffer decay.
// ----------------------------------------------------------------------------
`default_nettype none

module skg_meter (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire skg_pkg::meter_ctrl_t ctrl,
  input  wire logic [14:0]          mag,
  output skg_pkg::meter_stat_t      stat
);
  import skg_pkg::*;

  logic [14:0] running_peak;
  logic [3:0]  meter_bars;
  logic [14:0] peak_seen;
  logic [3:0]  measured;
  logic [3:0]  bars_next;
  logic [3:0]  bars_less;

  always_comb begin
    peak_seen = (mag > running_peak) ? mag : running_peak;
    measured  = bar_count(peak_seen);
    bars_less = meter_bars - 4'd1;
    // rise at once, fall by one bar at most
    if (measured >= meter_bars) begin
      bars_next = measured;
    end else if (bars_less > measured) begin
      bars_next = bars_less;
    end else begin
      bars_next = measured;
    end
    stat.peak = peak_seen;
    stat.bars = ctrl.last ? bars_next : meter_bars;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_peak <= '0;
      meter_bars   <= '0;
    end else if (ctrl.advance) begin
      if (ctrl.last) begin
        running_peak <= '0;
        meter_bars   <= bars_next;
      end else begin
        running_peak <= peak_seen;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/soft_knee_gain_vu_meter.sv
// ----------------------------------------------------------------------------
// soft_knee_gain_vu_meter
// Gain stage with soft knee limiting and a buffer peak VU meter.
// ----------------------------------------------------------------------------
// Channel  Handshake            Payload
// in       in_valid/in_ready    sample_in, last_in_buffer
// out      out_valid/out_ready  sample_out, level_bars, buffer_peak, last_out
// cfg      APB psel/penable     paddr, pwdata, prdata (knee_threshold at 0)
//
// One word per cycle sustained while the output keeps taking words;
// each word goes to the input register, then to the result register.
// Peak and bar state update as a word moves into the result register.
// A stalled output holds its word; the input register keeps taking words
// until it is full as well. rst clears both stages and the meter state.
// ----------------------------------------------------------------------------
`default_nettype none

module soft_knee_gain_vu_meter (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic signed [15:0]         sample_in,
  input  wire logic                       last_in_buffer,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed [15:0]              sample_out,
  output logic [3:0]                      level_bars,
  output logic [14:0]                     buffer_peak,
  output logic                            last_out,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [skg_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import skg_pkg::*;

  logic [14:0]        knee;
  logic               s1_valid;
  logic signed [15:0] s1_sample;
  logic               s1_last;
  logic               advance;
  logic signed [15:0] shaped;
  logic [14:0]        mag;
  meter_ctrl_t        mctrl;
  meter_stat_t        mstat;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      knee <= KNEE_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_KNEE_IDX: knee <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_KNEE_IDX: prdata = {17'd0, knee};
      default:      prdata = '0;
    endcase
  end

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_sample <= sample_in;
      s1_last   <= last_in_buffer;
    end
  end

  skg_shape u_shape (
    .sample (s1_sample),
    .knee   (knee),
    .shaped (shaped),
    .mag    (mag)
  );

  assign mctrl.advance = advance;
  assign mctrl.last    = s1_last;

  skg_meter u_meter (
    .clk  (clk),
    .rst  (rst),
    .ctrl (mctrl),
    .mag  (mag),
    .stat (mstat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sample_out  <= shaped;
      level_bars  <= mstat.bars;
      buffer_peak <= mstat.peak;
      last_out    <= s1_last;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/skg_checker.sv
// ----------------------------------------------------------------------------
// skg_checker
// Port-level checks on the result channel of the soft knee gain VU meter.
// ----------------------------------------------------------------------------
`default_nettype none

`include "soft_knee_gain_vu_meter_defines.svh"

module skg_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [15:0] sample_out,
  input wire logic [3:0]         level_bars,
  input wire logic [14:0]        buffer_peak,
  input wire logic               last_out
);

  logic [15:0] out_mag;

  assign out_mag = sample_out[15] ? (16'd0 - 16'(sample_out)) : 16'(sample_out);

  `SKG_ASSERT_NEXT(a_reset_empty, rst, !out_valid, "output valid straight after reset")
  `SKG_ASSERT_NEXT(a_hold_stall, !rst && out_valid && !out_ready,
                   out_valid && $stable(sample_out) && $stable(level_bars) &&
                   $stable(buffer_peak) && $stable(last_out),
                   "stalled result word changed")
  `SKG_ASSERT_ALWAYS(a_no_min_code, !out_valid || sample_out != -16'sd32768,
                     "sample_out reached the most negative code")
  `SKG_ASSERT_ALWAYS(a_bars_range, !out_valid || level_bars <= 4'd12,
                     "level_bars above twelve")
  `SKG_ASSERT_ALWAYS(a_peak_covers, !out_valid || out_mag <= {1'b0, buffer_peak},
                     "buffer_peak below the magnitude of sample_out")

endmodule

bind soft_knee_gain_vu_meter skg_checker u_skg_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .sample_out  (sample_out),
  .level_bars  (level_bars),
  .buffer_peak (buffer_peak),
  .last_out    (last_out)
);

`default_nettype wire

FILE: test/soft_knee_gain_vu_meter_tb.sv
// ----------------------------------------------------------------------------
// soft_knee_gain_vu_meter_tb
// Streams signed audio words through the gain stage under several knee
// settings. A local predictor tracks the knee, buffer peak and meter bars.
// Each output word is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module soft_knee_gain_vu_meter_tb;

  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 8;
  localparam int REPORT_LIMIT    = 200;
  localparam int PHASE_WORDS     = 150;

  localparam logic [skg_pkg::ADDR_W-1:0] KNEE_ADDR     = {skg_pkg::REG_KNEE_IDX, 2'b00};
  localparam logic [skg_pkg::ADDR_W-1:0] UNMAPPED_ADDR = 3'd4;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
  } audio_word_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic [3:0]         bars;
    logic [14:0]        peak;
    logic               last;
  } gain_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [15:0]        sample_in = '0;
  logic                      last_in_buffer = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [15:0]        sample_out;
  logic [3:0]                level_bars;
  logic [14:0]               buffer_peak;
  logic                      last_out;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [skg_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0]               pwdata = '0;
  logic [31:0]               prdata;
  logic                      pready;

  soft_knee_gain_vu_meter u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .sample_in     (sample_in),
    .last_in_buffer(last_in_buffer),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .sample_out    (sample_out),
    .level_bars    (level_bars),
    .buffer_peak   (buffer_peak),
    .last_out      (last_out),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  audio_word_t  sample_backlog[$];
  gain_result_t expected_words[$];

  logic [14:0] knee_setting = skg_pkg::KNEE_RESET;
  logic [14:0] peak_so_far  = '0;
  logic [3:0]  meter_level  = '0;
  int          error_count  = 0;

  logic hold_off_req = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic void report_mismatch(string field, int want, int got);
    error_count++;
    if (error_count <= REPORT_LIMIT) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endfunction

  // gain, knee, clamp and meter update for one accepted word
  function automatic void knee_gain_predict(input logic signed [15:0] raw, input logic last);
    logic [16:0]  mag;
    logic         neg;
    int           measured;
    gain_result_t r;
    neg = raw[15];
    mag = neg ? ((17'h10000 - {1'b0, raw}) << 1) : {raw, 1'b0};
    if (mag > {2'b00, knee_setting}) begin
      mag = {2'b00, knee_setting} + ((mag - {2'b00, knee_setting}) >> skg_pkg::KNEE_SHIFT);
    end
    if (mag > {2'b00, skg_pkg::MAG_CLAMP}) begin
      mag = {2'b00, skg_pkg::MAG_CLAMP};
    end
    r.sample = neg ? 16'(17'h10000 - mag) : mag[15:0];
    if (mag[14:0] > peak_so_far) begin
      peak_so_far = mag[14:0];
    end
    r.peak = peak_so_far;
    if (last) begin
      measured = int'(peak_so_far) / skg_pkg::BAR_STEP;
      if (measured > skg_pkg::BAR_MAX) begin
        measured = skg_pkg::BAR_MAX;
      end
      // rise at once, decay by a single bar per buffer
      if (measured >= int'(meter_level)) begin
        meter_level = 4'(measured);
      end else begin
        meter_level = meter_level - 4'd1;
      end
      peak_so_far = '0;
    end
    r.bars = meter_level;
    r.last = last;
    expected_words.push_back(r);
  endfunction

  // ---------------------------------------------------------------- sender
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    logic        taken;
    audio_word_t w;
    if (rst) begin
      in_valid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      taken = in_valid && in_ready;
      if (taken) begin
        knee_gain_predict(sample_in, last_in_buffer);
      end
      // hold the word until it is taken
      if (!in_valid || taken) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (sample_backlog.size() > 0) begin
          w = sample_backlog.pop_front();
          sample_in      <= w.sample;
          last_in_buffer <= w.last;
          in_valid       <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------------------- receiver
  logic [15:0] stall_pattern = '1;
  int          pattern_pos   = 0;
  int          hold_count    = 0;
  logic        hold_off_done = 1'b0;

  always @(posedge clk) begin
    logic ready_next;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_off_req && !hold_off_done) begin
        if (hold_count == HOLD_OFF_CYCLES) begin
          hold_off_done <= 1'b1;
          ready_next = 1'b1;
        end else begin
          hold_count <= hold_count + 1;
          ready_next = 1'b0;
        end
      end else begin
        ready_next = stall_pattern[pattern_pos];
        if (pattern_pos == 15) begin
          pattern_pos <= 0;
          case ($urandom_range(0, 3))
            0:       stall_pattern <= '1;
            1:       stall_pattern <= 16'($urandom);
            2:       stall_pattern <= 16'($urandom | $urandom);
            default: stall_pattern <= 16'($urandom & $urandom);
          endcase
        end else begin
          pattern_pos <= pattern_pos + 1;
        end
      end
      out_ready <= ready_next;
    end
  end

  // --------------------------------------------------------------- checker
  always @(posedge clk) begin
    gain_result_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
          $display("%0t: output word with nothing expected, sample %0d", $time, sample_out);
        end
      end else begin
        e = expected_words.pop_front();
        if (sample_out !== e.sample) report_mismatch("sample_out", e.sample, sample_out);
        if (level_bars !== e.bars) report_mismatch("level_bars", e.bars, level_bars);
        if (buffer_peak !== e.peak) report_mismatch("buffer_peak", e.peak, buffer_peak);
        if (last_out !== e.last) report_mismatch("last_out", e.last, last_out);
      end
    end
  end

  // -------------------------------------------------------------- stimulus
  task automatic reg_access(input logic [skg_pkg::ADDR_W-1:0] addr, input logic wr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    if (wr && addr == KNEE_ADDR) begin
      knee_setting = wdata[14:0];
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_knee_readback();
    logic [31:0] rd;
    reg_access(KNEE_ADDR, 1'b0, 32'd0, rd);
    if (rd[14:0] !== knee_setting) report_mismatch("knee_threshold readback", knee_setting, rd[14:0]);
  endtask

  task automatic set_knee(input logic [14:0] knee);
    logic [31:0] rd;
    // junk in the upper bits must be dropped
    reg_access(KNEE_ADDR, 1'b1, {17'($urandom), knee}, rd);
    check_knee_readback();
  endtask

  task automatic settle_block();
    while (sample_backlog.size() != 0 || in_valid || expected_words.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic void queue_word(input logic signed [15:0] s, input logic l);
    audio_word_t w;
    w.sample = s;
    w.last   = l;
    sample_backlog.push_back(w);
  endfunction

  task automatic queue_random_buffers(input int count);
    int                 left;
    int                 len;
    int                 amp;
    logic signed [15:0] s;
    logic               l;
    left = count;
    while (left > 0) begin
      len = $urandom_range(1, 16);
      case ($urandom_range(0, 3))
        0:       amp = $urandom_range(0, 32767);
        1:       amp = $urandom_range(0, 3000);
        2:       amp = $urandom_range(8000, 20000);
        default: amp = $urandom_range(12000, 16383);
      endcase
      for (int i = 0; i < len && left > 0; i++) begin
        case ($urandom_range(0, 19))
          0:       s = 16'($urandom);
          1:       s = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
          default: begin
            s = 16'($urandom_range(0, amp));
            if ($urandom_range(0, 1)) s = -s;
          end
        endcase
        // mostly whole buffers, now and then a stray or missing end marker
        if ($urandom_range(0, 9) == 0) begin
          l = 1'($urandom_range(0, 1));
        end else begin
          l = (i == len - 1) || (left == 1);
        end
        queue_word(s, l);
        left--;
      end
    end
  endtask

  initial begin
    logic [31:0] rd;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset knee, edges of the sample range and meter rise then decay
    check_knee_readback();
    queue_word(16'sd0, 1'b0);
    queue_word(16'sd1, 1'b0);
    queue_word(-16'sd1, 1'b0);
    queue_word(16'sh7FFF, 1'b0);
    queue_word(16'sh8000, 1'b1);
    queue_word(16'sd12250, 1'b1);
    queue_word(16'sd12251, 1'b0);
    queue_word(16'sd12252, 1'b0);
    queue_word(-16'sd16384, 1'b1);
    queue_word(16'sd1150, 1'b1);
    queue_word(16'sd1149, 1'b1);
    for (int i = 0; i < 6; i++) queue_word(16'sd0, 1'b1);
    queue_word(16'sd16383, 1'b0);
    queue_word(16'sd16384, 1'b0);
    queue_word(-16'sd16383, 1'b1);
    queue_word(-16'sd2, 1'b1);
    queue_random_buffers(PHASE_WORDS);
    settle_block();

    // knee at zero: whole doubled magnitude divided by four
    set_knee(15'd0);
    queue_word(16'sh8000, 1'b0);
    queue_word(16'sh7FFF, 1'b0);
    queue_word(-16'sd1, 1'b0);
    queue_word(16'sd1, 1'b1);
    queue_random_buffers(PHASE_WORDS);
    settle_block();

    // knee at the top: plain gain then clamp
    set_knee(15'd32767);
    queue_word(16'sh8000, 1'b0);
    queue_word(16'sh7FFF, 1'b1);
    queue_random_buffers(PHASE_WORDS);
    settle_block();

    // long output stall while words keep coming
    set_knee(15'($urandom_range(1, 32766)));
    hold_off_req <= 1'b1;
    queue_random_buffers(PHASE_WORDS);
    settle_block();

    // write outside the map must leave the knee alone
    reg_access(UNMAPPED_ADDR, 1'b1, $urandom, rd);
    check_knee_readback();
    set_knee(15'd1);
    queue_random_buffers(PHASE_WORDS);
    settle_block();

    set_knee(15'd12000);
    queue_random_buffers(PHASE_WORDS);
    settle_block();

    set_knee(15'($urandom_range(0, 32767)));
    queue_random_buffers(PHASE_WORDS);
    settle_block();

    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
